[rtl/scrq_pkg.sv]
package scrq_pkg;

	localparam int QUEUE_DEPTH = 32;
	localparam int PTR_W       = $clog2(QUEUE_DEPTH);
	localparam int NUM_CNT     = 7;
	localparam int CNT_W       = 32;
	localparam int DCNT_W      = 6;

	localparam logic [7:0] PARITY_MASK  = 8'h80;
	localparam logic [7:0] TIMEOUT_MASK = 8'h40;

	typedef logic [PTR_W-1:0] ptr_t;

	typedef enum logic [1:0] {
		OP_KEY   = 2'd0,
		OP_DRAIN = 2'd1,
		OP_READ  = 2'd2,
		OP_CLEAR = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		K_QUEUED  = 3'd0,
		K_DROPPED = 3'd1,
		K_CODE    = 3'd2,
		K_RESYNC  = 3'd3,
		K_EMPTY   = 3'd4,
		K_COUNTER = 3'd5,
		K_CLEARED = 3'd6
	} kind_t;

	localparam logic [2:0] CNT_INTERRUPTS = 3'd0;
	localparam logic [2:0] CNT_QUEUED     = 3'd1;
	localparam logic [2:0] CNT_DRAINED    = 3'd2;
	localparam logic [2:0] CNT_OVERFLOW   = 3'd3;
	localparam logic [2:0] CNT_PARITY     = 3'd4;
	localparam logic [2:0] CNT_TIMEOUT    = 3'd5;
	localparam logic [2:0] CNT_RESYNC     = 3'd6;

	typedef struct packed {
		logic accept;
		logic step;
	} cmd_t;

	typedef struct packed {
		logic fault;
		logic empty;
		logic step_last;
	} stat_t;

	function automatic ptr_t ring_next(ptr_t p);
		return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : ptr_t'(p + 1'b1);
	endfunction

endpackage

[rtl/scrq_ctrl.sv]
module scrq_ctrl import scrq_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  start,
	input  op_t   op,
	input  stat_t stat,
	output cmd_t  cmd,
	output logic  busy
);

	typedef enum logic [1:0] {
		S_IDLE  = 2'b01,
		S_DRAIN = 2'b10
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		state_d    = state_q;
		cmd.accept = 1'b0;
		cmd.step   = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.accept = 1'b1;
					if (op == OP_DRAIN && !stat.fault && !stat.empty)
						state_d = S_DRAIN;
				end
			end
			S_DRAIN: begin
				cmd.step = 1'b1;
				if (stat.step_last)
					state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_IDLE;
		else
			state_q <= state_d;
	end

	assign busy = (state_q == S_DRAIN);

endmodule

[rtl/scrq_dp.sv]
module scrq_dp import scrq_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  cmd_t              cmd,
	input  op_t               op,
	input  logic [7:0]        status_byte,
	input  logic [7:0]        raw_code,
	input  logic [2:0]        counter_select,
	output stat_t             stat,
	output logic              done,
	output logic [2:0]        kind,
	output logic [7:0]        code_out,
	output logic [CNT_W-1:0]  counter_value,
	output logic [DCNT_W-1:0] drained_count,
	output logic              last
);

	logic [7:0]       mem [QUEUE_DEPTH];
	logic [7:0]       rdata_q;
	ptr_t             wr_ptr_q, rd_ptr_q, rd_addr, wr_next, rd_next;
	logic             fault_q;
	logic [CNT_W-1:0] cnt_q [NUM_CNT];
	logic [DCNT_W-1:0] dcnt_q;

	logic             par_err, tmo_err, fault_evt, full, store, ovf;
	logic             key, drain;

	logic             done_q, last_q;
	logic [2:0]       kind_q;
	logic [7:0]       code_q;
	logic [CNT_W-1:0] value_q;
	logic [DCNT_W-1:0] count_q;

	assign wr_next   = ring_next(wr_ptr_q);
	assign rd_next   = ring_next(rd_ptr_q);
	assign full      = (wr_next == rd_ptr_q);
	assign key       = cmd.accept && op == OP_KEY;
	assign drain     = cmd.accept && op == OP_DRAIN;
	assign par_err   = (status_byte & PARITY_MASK) != 8'h00;
	assign tmo_err   = (status_byte & TIMEOUT_MASK) != 8'h00;
	assign fault_evt = fault_q || par_err || tmo_err;
	assign store     = key && !fault_evt && !full;
	assign ovf       = key && !fault_evt && full;

	assign stat.fault     = fault_q;
	assign stat.empty     = (rd_ptr_q == wr_ptr_q);
	assign stat.step_last = (rd_next == wr_ptr_q);

	// look one entry ahead while draining so a code leaves every cycle
	assign rd_addr = cmd.step ? rd_next : rd_ptr_q;

	always_ff @(posedge clk) begin
		if (store)
			mem[wr_ptr_q] <= raw_code;
		rdata_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fault_q  <= 1'b0;
			dcnt_q   <= '0;
			for (int i = 0; i < NUM_CNT; i++)
				cnt_q[i] <= '0;
		end else begin
			if (store)
				wr_ptr_q <= wr_next;
			if (key && (par_err || tmo_err || ovf))
				fault_q <= 1'b1;
			if (key) begin
				cnt_q[CNT_INTERRUPTS] <= cnt_q[CNT_INTERRUPTS] + 1'b1;
				if (par_err)
					cnt_q[CNT_PARITY] <= cnt_q[CNT_PARITY] + 1'b1;
				if (tmo_err)
					cnt_q[CNT_TIMEOUT] <= cnt_q[CNT_TIMEOUT] + 1'b1;
				if (ovf)
					cnt_q[CNT_OVERFLOW] <= cnt_q[CNT_OVERFLOW] + 1'b1;
				if (store)
					cnt_q[CNT_QUEUED] <= cnt_q[CNT_QUEUED] + 1'b1;
			end
			// resync: discard the queue and drop the fault
			if (drain && fault_q) begin
				rd_ptr_q            <= wr_ptr_q;
				fault_q             <= 1'b0;
				cnt_q[CNT_RESYNC]   <= cnt_q[CNT_RESYNC] + 1'b1;
			end
			if (drain)
				dcnt_q <= '0;
			if (cmd.step) begin
				rd_ptr_q           <= rd_next;
				dcnt_q             <= dcnt_q + 1'b1;
				cnt_q[CNT_DRAINED] <= cnt_q[CNT_DRAINED] + 1'b1;
			end
			if (cmd.accept && op == OP_CLEAR)
				for (int i = 0; i < NUM_CNT; i++)
					cnt_q[i] <= '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			done_q <= 1'b0;
		else
			done_q <= cmd.step || (cmd.accept && !(drain && !fault_q && !stat.empty));
	end

	always_ff @(posedge clk) begin
		kind_q  <= K_EMPTY;
		code_q  <= '0;
		value_q <= '0;
		count_q <= '0;
		last_q  <= 1'b1;
		if (cmd.step) begin
			kind_q  <= K_CODE;
			code_q  <= rdata_q;
			last_q  <= stat.step_last;
			if (stat.step_last)
				count_q <= dcnt_q + 1'b1;
		end else begin
			case (op)
				OP_KEY:   kind_q <= store ? K_QUEUED : K_DROPPED;
				OP_DRAIN: kind_q <= fault_q ? K_RESYNC : K_EMPTY;
				OP_READ: begin
					kind_q  <= K_COUNTER;
					value_q <= (counter_select < 3'(NUM_CNT)) ? cnt_q[counter_select] : '0;
				end
				default:  kind_q <= K_CLEARED;
			endcase
		end
	end

	assign done          = done_q;
	assign kind          = kind_q;
	assign code_out      = code_q;
	assign counter_value = value_q;
	assign drained_count = count_q;
	assign last          = last_q;

endmodule

[rtl/scancode_ring_queue_with_fault_latch.sv]
// Scan-code ring queue with fault latch and seven 32-bit event counters.
// Raise start with the item fields; the item is taken at a clock edge where
// busy is low. Every result shows on the result ports for exactly one cycle
// with done high; it cannot be held off, so capture it when done is seen.
// Key events, counter reads, counter clears, resyncs and drains of an empty
// ring give their one result in the cycle right after the item is taken and
// never raise busy, so such items may be issued every cycle. A drain of n
// queued codes holds busy high from right after it is taken until its last
// code steps out; the oldest code is read from the ring in the cycle the item
// is taken, and each busy cycle registers one code result and reads the next,
// so its n results follow one per cycle, one ring memory read per cycle. The
// last one carries last and drained_count. The ring holds QUEUE_DEPTH-1 codes.
module scancode_ring_queue_with_fault_latch import scrq_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  logic [1:0]        opcode,
	input  logic [7:0]        status_byte,
	input  logic [7:0]        raw_code,
	input  logic [2:0]        counter_select,
	output logic              done,
	output logic [2:0]        kind,
	output logic [7:0]        code_out,
	output logic [CNT_W-1:0]  counter_value,
	output logic [DCNT_W-1:0] drained_count,
	output logic              last
);

	cmd_t  cmd;
	stat_t stat;
	op_t   op;

	assign op = op_t'(opcode);

	scrq_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.op     (op),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy)
	);

	scrq_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.op             (op),
		.status_byte    (status_byte),
		.raw_code       (raw_code),
		.counter_select (counter_select),
		.stat           (stat),
		.done           (done),
		.kind           (kind),
		.code_out       (code_out),
		.counter_value  (counter_value),
		.drained_count  (drained_count),
		.last           (last)
	);

	a_drain_no_fault: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> !stat.fault && !stat.empty)
		else $error("drain running with fault latched or empty ring");

	a_single_result: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && opcode != 2'(OP_DRAIN)) |=> done && last)
		else $error("single-result item gave no final result");

	a_drain_count: assert property (@(posedge clk) disable iff (!arst_n)
		(done && kind == 3'(K_CODE) && last) |-> drained_count != '0)
		else $error("final drained code without a count");

	a_step_emits: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.step |=> done && kind == 3'(K_CODE))
		else $error("drain step gave no code result");

endmodule

[tb/scancode_ring_queue_with_fault_latch_tb.sv]
`timescale 1ns / 1ps

module scancode_ring_queue_with_fault_latch_tb;
	import scrq_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int RANDOM_ITEMS = 480;

	typedef struct {
		kind_t             kind;
		logic [7:0]        code;
		logic [CNT_W-1:0]  value;
		logic [DCNT_W-1:0] count;
		logic              last;
	} queue_result_t;

	class ring_queue_model;
		logic [7:0]     ring [QUEUE_DEPTH];
		ptr_t           wr_ptr;
		ptr_t           rd_ptr;
		logic           fault;
		bit [CNT_W-1:0] tallies [NUM_CNT];
		queue_result_t  awaited_results [$];
		int             items;
		int             errors;
		int             kinds_seen [8];

		function new();
			wr_ptr = '0;
			rd_ptr = '0;
			fault = 1'b0;
			foreach (tallies[i]) tallies[i] = '0;
			foreach (kinds_seen[i]) kinds_seen[i] = 0;
			items = 0;
			errors = 0;
		endfunction

		function ptr_t advance(ptr_t p);
			return (int'(p) == QUEUE_DEPTH - 1) ? ptr_t'(0) : ptr_t'(int'(p) + 1);
		endfunction

		function int fill_level();
			return (int'(wr_ptr) - int'(rd_ptr) + QUEUE_DEPTH) % QUEUE_DEPTH;
		endfunction

		function int pending();
			return awaited_results.size();
		endfunction

		function void await_result(kind_t k, logic [7:0] c, logic [CNT_W-1:0] v,
				logic [DCNT_W-1:0] n, logic l);
			queue_result_t r;
			r.kind = k;
			r.code = c;
			r.value = v;
			r.count = n;
			r.last = l;
			awaited_results.push_back(r);
			kinds_seen[k]++;
		endfunction

		// work out the results of one accepted item
		function void take_item(op_t op, logic [7:0] status, logic [7:0] code,
				logic [2:0] sel);
			ptr_t nxt;
			ptr_t p;
			int   n;
			logic stored;
			items++;
			case (op)
				OP_KEY: begin
					stored = 1'b0;
					tallies[CNT_INTERRUPTS]++;
					if ((status & PARITY_MASK) != 0) begin
						tallies[CNT_PARITY]++;
						fault = 1'b1;
					end
					if ((status & TIMEOUT_MASK) != 0) begin
						tallies[CNT_TIMEOUT]++;
						fault = 1'b1;
					end
					if (!fault) begin
						nxt = advance(wr_ptr);
						if (nxt == rd_ptr) begin
							tallies[CNT_OVERFLOW]++;
							fault = 1'b1;
						end else begin
							ring[wr_ptr] = code;
							wr_ptr = nxt;
							tallies[CNT_QUEUED]++;
							stored = 1'b1;
						end
					end
					await_result(stored ? K_QUEUED : K_DROPPED, '0, '0, '0, 1'b1);
				end
				OP_DRAIN: begin
					if (fault) begin
						// discard the queue and resync
						rd_ptr = wr_ptr;
						fault = 1'b0;
						tallies[CNT_RESYNC]++;
						await_result(K_RESYNC, '0, '0, '0, 1'b1);
					end else if (rd_ptr == wr_ptr) begin
						await_result(K_EMPTY, '0, '0, '0, 1'b1);
					end else begin
						n = 0;
						p = rd_ptr;
						while (p != wr_ptr) begin
							n++;
							if (advance(p) == wr_ptr)
								await_result(K_CODE, ring[p], '0, DCNT_W'(n), 1'b1);
							else
								await_result(K_CODE, ring[p], '0, '0, 1'b0);
							p = advance(p);
						end
						rd_ptr = p;
						tallies[CNT_DRAINED] += CNT_W'(n);
					end
				end
				OP_READ: begin
					await_result(K_COUNTER, '0, (int'(sel) < NUM_CNT) ? tallies[sel] : '0,
						'0, 1'b1);
				end
				default: begin
					foreach (tallies[i]) tallies[i] = '0;
					await_result(K_CLEARED, '0, '0, '0, 1'b1);
				end
			endcase
		endfunction

		task report(string what);
			errors++;
			if (errors <= 30)
				$display("%0t mismatch: %s", $realtime, what);
		endtask

		task compare_field(string name, logic [CNT_W-1:0] got, logic [CNT_W-1:0] want);
			if (got !== want)
				report($sformatf("%s got 0x%0h want 0x%0h", name, got, want));
		endtask

		task match_result(logic [2:0] k, logic [7:0] c, logic [CNT_W-1:0] v,
				logic [DCNT_W-1:0] n, logic l);
			queue_result_t w;
			if (awaited_results.size() == 0) begin
				report($sformatf("unexpected result kind %0d", k));
			end else begin
				w = awaited_results.pop_front();
				compare_field("kind", CNT_W'(k), CNT_W'(w.kind));
				compare_field("code_out", CNT_W'(c), CNT_W'(w.code));
				compare_field("counter_value", v, w.value);
				compare_field("drained_count", CNT_W'(n), CNT_W'(w.count));
				compare_field("last", CNT_W'(l), CNT_W'(w.last));
			end
		endtask
	endclass

	logic              clk = 1'b0;
	logic              arst_n;
	logic              start;
	logic              busy;
	logic [1:0]        opcode;
	logic [7:0]        status_byte;
	logic [7:0]        raw_code;
	logic [2:0]        counter_select;
	logic              done;
	logic [2:0]        kind;
	logic [7:0]        code_out;
	logic [CNT_W-1:0]  counter_value;
	logic [DCNT_W-1:0] drained_count;
	logic              last;

	ring_queue_model   sb;
	int                cycles = 0;
	int                idle_pct = 0;

	scancode_ring_queue_with_fault_latch u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.opcode        (opcode),
		.status_byte   (status_byte),
		.raw_code      (raw_code),
		.counter_select(counter_select),
		.done          (done),
		.kind          (kind),
		.code_out      (code_out),
		.counter_value (counter_value),
		.drained_count (drained_count),
		.last          (last)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n && done)
			sb.match_result(kind, code_out, counter_value, drained_count, last);
		if (arst_n && start && !busy)
			sb.take_item(op_t'(opcode), status_byte, raw_code, counter_select);
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("[scancode_ring_queue_with_fault_latch] ERROR");
			$finish;
		end
	end

	// present one item and hold it until the block takes it
	task automatic send_item(op_t op, logic [7:0] st, logic [7:0] sc, logic [2:0] sel);
		@(negedge clk);
		start <= 1'b1;
		opcode <= op;
		status_byte <= st;
		raw_code <= sc;
		counter_select <= sel;
		do @(posedge clk); while (busy);
	endtask

	// idle each following cycle with the phase's odds
	task automatic maybe_idle();
		while ($urandom_range(0, 99) < idle_pct) begin
			@(negedge clk);
			start <= 1'b0;
		end
	endtask

	task automatic send_paced(op_t op, logic [7:0] st, logic [7:0] sc, logic [2:0] sel);
		send_item(op, st, sc, sel);
		maybe_idle();
	endtask

	task automatic wait_quiet();
		@(negedge clk);
		start <= 1'b0;
		while (sb.pending() > 0) @(posedge clk);
	endtask

	task automatic send_clean_key();
		send_paced(OP_KEY, 8'($urandom_range(0, 63)), 8'($urandom_range(0, 255)), '0);
	endtask

	task automatic run_burst();
		int r;
		int n;
		logic [7:0] bad;
		r = $urandom_range(0, 99);
		if (r < 45) begin
			n = $urandom_range(1, 6);
			repeat (n) send_clean_key();
			if ($urandom_range(0, 9) < 7)
				send_paced(OP_DRAIN, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
					3'($urandom_range(0, 7)));
		end else if (r < 52) begin
			// fill up to or past the last free slot, then drain or recover
			n = QUEUE_DEPTH - 1 - sb.fill_level() + $urandom_range(0, 2);
			repeat (n) send_clean_key();
			send_paced(OP_DRAIN, '0, '0, '0);
		end else if (r < 62) begin
			case ($urandom_range(0, 2))
				0: bad = PARITY_MASK;
				1: bad = TIMEOUT_MASK;
				default: bad = PARITY_MASK | TIMEOUT_MASK;
			endcase
			send_paced(OP_KEY, bad | 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), '0);
			n = $urandom_range(0, 3);
			repeat (n) send_clean_key();
			send_paced(OP_DRAIN, '0, '0, '0);
		end else if (r < 80) begin
			n = $urandom_range(1, 3);
			repeat (n)
				send_paced(OP_READ, '0, '0, 3'($urandom_range(0, 7)));
			if ($urandom_range(0, 99) < 15)
				send_paced(OP_CLEAR, '0, '0, '0);
		end else begin
			n = $urandom_range(1, 4);
			repeat (n)
				send_paced(op_t'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
					8'($urandom_range(0, 255)), 3'($urandom_range(0, 7)));
		end
	endtask

	initial begin
		int phase_pct [4];
		int goal;
		sb = new();
		arst_n = 1'b0;
		start = 1'b0;
		opcode = OP_KEY;
		status_byte = '0;
		raw_code = '0;
		counter_select = '0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed: counters at reset, extremes, faults, resync, clear
		for (int s = 0; s < 8; s++) send_item(OP_READ, '0, '0, 3'(s));
		send_item(OP_KEY, 8'h00, 8'h00, '0);
		send_item(OP_KEY, 8'h3F, 8'hFF, '0);
		send_item(OP_DRAIN, '0, '0, '0);
		send_item(OP_DRAIN, '0, '0, '0);
		send_item(OP_KEY, PARITY_MASK, 8'hA5, '0);
		send_item(OP_KEY, 8'h00, 8'h5A, '0);
		send_item(OP_DRAIN, '0, '0, '0);
		send_item(OP_KEY, TIMEOUT_MASK, 8'h3C, '0);
		send_item(OP_KEY, PARITY_MASK | TIMEOUT_MASK, 8'hC3, '0);
		send_item(OP_DRAIN, '0, '0, '0);
		send_item(OP_READ, '0, '0, CNT_PARITY);
		send_item(OP_READ, '0, '0, CNT_TIMEOUT);
		send_item(OP_READ, '0, '0, CNT_RESYNC);
		send_item(OP_READ, '0, '0, CNT_INTERRUPTS);
		send_item(OP_CLEAR, 8'hFF, 8'hFF, 3'd7);
		send_item(OP_READ, '0, '0, CNT_QUEUED);
		wait_quiet();

		// random phases: no idling, heavy sender gaps, none, light gaps
		phase_pct = '{0, 66, 0, 21};
		for (int ph = 0; ph < 4; ph++) begin
			idle_pct = phase_pct[ph];
			goal = sb.items + RANDOM_ITEMS / 4;
			while (sb.items < goal) run_burst();
			wait_quiet();
		end

		repeat (8) @(posedge clk);
		if (sb.pending() != 0)
			sb.report($sformatf("%0d results never arrived", sb.pending()));
		$display("covered %0d items: %0d codes drained, %0d resyncs, %0d drops",
			sb.items, sb.kinds_seen[K_CODE], sb.kinds_seen[K_RESYNC], sb.kinds_seen[K_DROPPED]);
		$display("  %0d empty drains, %0d counter reads, %0d clears, %0d mismatches",
			sb.kinds_seen[K_EMPTY], sb.kinds_seen[K_COUNTER], sb.kinds_seen[K_CLEARED],
			sb.errors);
		if (sb.errors == 0)
			$display("[scancode_ring_queue_with_fault_latch] OK");
		else
			$display("[scancode_ring_queue_with_fault_latch] ERROR");
		$finish;
	end

endmodule
